FILE: hdl/dbsf_pkg.sv
// package for the dle/stx/etx byte stuffing framer
// payload structs, command struct, sequencer phases and line symbols
// no dependencies
package dbsf_pkg;

  localparam int unsigned MAX_PAYLOAD_BYTES = 256;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam int unsigned CFG_IDX_W         = 1;
  localparam int unsigned CFG_DATA_W        = 32;
  localparam int unsigned HDR_LEN           = 10;
  localparam int unsigned HDR_IDX_W         = 4;

  localparam logic [7:0] SYM_DLE = 8'h10;
  localparam logic [7:0] SYM_STX = 8'h02;
  localparam logic [7:0] SYM_ETX = 8'h03;

  localparam logic [CFG_IDX_W-1:0] REG_DEST_ID   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ID = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_frame;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_done;
    logic       run_last;
  } result_t;

  // one classified item handed from front to back
  typedef struct packed {
    logic       open;
    logic       has_byte;
    logic       is_dle;
    logic       close;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_HDR,
    PH_STUFF,
    PH_DATA,
    PH_DLE,
    PH_ETX
  } phase_t;

endpackage

FILE: hdl/dbsf_fifo.sv
// small two-entry register queue used between front and back and on the output
// depends on dbsf_pkg for the depth
module dbsf_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int unsigned DEPTH = dbsf_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/dbsf_front.sv
// front end: accepts input items, tracks frame state and payload count,
// and turns each item that carries a byte or a frame end into a command; depends on dbsf_pkg
module dbsf_front #(
  parameter int unsigned MAX_PAYLOAD_BYTES = dbsf_pkg::MAX_PAYLOAD_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dbsf_pkg::item_t     item,
  input  logic                cmd_full,
  output logic                cmd_push,
  output dbsf_pkg::cmd_t      cmd,
  output logic                in_frame
);

  localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD_BYTES + 1);

  logic [CNT_W-1:0] payload_count;
  logic             accept;
  logic             active;
  logic             hit_max;

  assign accept     = push && !cmd_full;
  // idle items are taken but leave no trace
  assign active     = item.has_byte || item.end_of_frame;
  assign cmd_push   = accept && active;

  // the count is cleared on every close, so it never passes max - 1
  assign hit_max = item.has_byte && (payload_count == CNT_W'(MAX_PAYLOAD_BYTES - 1));

  always_comb begin
    cmd.open     = !in_frame;
    cmd.has_byte = item.has_byte;
    cmd.is_dle   = (item.data_byte == dbsf_pkg::SYM_DLE);
    cmd.close    = item.end_of_frame || hit_max;
    cmd.data     = item.data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      payload_count <= '0;
    end else if (cmd_push) begin
      if (cmd.close) begin
        in_frame      <= 1'b0;
        payload_count <= '0;
      end else begin
        in_frame <= 1'b1;
        if (!in_frame) begin
          payload_count <= CNT_W'(item.has_byte);
        end else if (item.has_byte) begin
          payload_count <= payload_count + 1'b1;
        end
      end
    end
  end

endmodule

FILE: hdl/dbsf_back.sv
// back end: steps through the line bytes of the command at the queue head,
// one byte per cycle into the output queue when it is not full; depends on dbsf_pkg
module dbsf_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_empty,
  input  dbsf_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  input  logic [31:0]         dest_id,
  input  logic [31:0]         source_id,
  input  logic                out_full,
  output logic                out_push,
  output dbsf_pkg::result_t   out_res
);

  dbsf_pkg::phase_t                   ph;
  dbsf_pkg::phase_t                   ph_next;
  dbsf_pkg::phase_t                   cur;
  dbsf_pkg::phase_t                   nxt;
  logic [dbsf_pkg::HDR_IDX_W-1:0]     idx;
  logic [dbsf_pkg::HDR_IDX_W-1:0]     idx_next;
  logic [7:0]                         hdr_byte;
  logic                               emit;

  // phase that follows the header or starts a command without one
  function automatic dbsf_pkg::phase_t body_phase(input dbsf_pkg::cmd_t c);
    dbsf_pkg::phase_t p;
    if (c.has_byte) begin
      p = c.is_dle ? dbsf_pkg::PH_STUFF : dbsf_pkg::PH_DATA;
    end else if (c.close) begin
      p = dbsf_pkg::PH_DLE;
    end else begin
      p = dbsf_pkg::PH_START;
    end
    return p;
  endfunction

  always_comb begin
    case (idx)
      4'd0:    hdr_byte = dbsf_pkg::SYM_DLE;
      4'd1:    hdr_byte = dbsf_pkg::SYM_STX;
      4'd2:    hdr_byte = dest_id[7:0];
      4'd3:    hdr_byte = dest_id[15:8];
      4'd4:    hdr_byte = dest_id[23:16];
      4'd5:    hdr_byte = dest_id[31:24];
      4'd6:    hdr_byte = source_id[7:0];
      4'd7:    hdr_byte = source_id[15:8];
      4'd8:    hdr_byte = source_id[23:16];
      4'd9:    hdr_byte = source_id[31:24];
      default: hdr_byte = 8'h00;
    endcase
  end

  assign emit = !cmd_empty && !out_full;

  always_comb begin
    if (ph == dbsf_pkg::PH_START) begin
      cur = cmd.open ? dbsf_pkg::PH_HDR : body_phase(cmd);
    end else begin
      cur = ph;
    end

    idx_next            = idx;
    out_res.frame_done  = 1'b0;
    case (cur)
      dbsf_pkg::PH_HDR: begin
        out_res.out_byte = hdr_byte;
        if (idx == dbsf_pkg::HDR_IDX_W'(dbsf_pkg::HDR_LEN - 1)) begin
          nxt      = body_phase(cmd);
          idx_next = '0;
        end else begin
          nxt      = dbsf_pkg::PH_HDR;
          idx_next = idx + 1'b1;
        end
      end
      dbsf_pkg::PH_STUFF: begin
        out_res.out_byte = dbsf_pkg::SYM_DLE;
        nxt              = dbsf_pkg::PH_DATA;
      end
      dbsf_pkg::PH_DATA: begin
        out_res.out_byte = cmd.data;
        nxt              = cmd.close ? dbsf_pkg::PH_DLE : dbsf_pkg::PH_START;
      end
      dbsf_pkg::PH_DLE: begin
        out_res.out_byte = dbsf_pkg::SYM_DLE;
        nxt              = dbsf_pkg::PH_ETX;
      end
      dbsf_pkg::PH_ETX: begin
        out_res.out_byte   = dbsf_pkg::SYM_ETX;
        out_res.frame_done = 1'b1;
        nxt                = dbsf_pkg::PH_START;
      end
      default: begin
        out_res.out_byte = 8'h00;
        nxt              = dbsf_pkg::PH_START;
      end
    endcase

    out_res.run_last = (nxt == dbsf_pkg::PH_START);
    out_push         = emit;
    cmd_pop          = emit && out_res.run_last;
    ph_next          = emit ? nxt : ph;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph  <= dbsf_pkg::PH_START;
      idx <= '0;
    end else begin
      ph <= ph_next;
      if (emit) begin
        idx <= idx_next;
      end
    end
  end

endmodule

FILE: hdl/dle_byte_stuffing_framer.sv
// dle/stx/etx byte stuffing framer, top level
// an item passes the command queue, the back sequencer and the output queue to the result ports
// throughput: the back sequencer gives one line byte per cycle when out_full is low; an
// active item makes 1 to 14 line bytes (1 plain, 2 if stuffed, +2 to close, +10 on open)
// reset: rst synchronous, clears the frame state, both queues and the id registers
module dle_byte_stuffing_framer #(
  parameter int unsigned MAX_PAYLOAD_BYTES = dbsf_pkg::MAX_PAYLOAD_BYTES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  dbsf_pkg::item_t                   item,
  output logic                              full,
  input  logic                              pop,
  output dbsf_pkg::result_t                 result,
  output logic                              empty,
  input  logic                              cfg_we,
  input  logic [dbsf_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [dbsf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [31:0]        dest_id;
  logic [31:0]        source_id;
  logic               cmd_push;
  logic               cmd_pop;
  logic               cmd_full;
  logic               cmd_empty;
  dbsf_pkg::cmd_t     cmd_in;
  dbsf_pkg::cmd_t     cmd_head;
  logic               out_push;
  logic               out_full;
  dbsf_pkg::result_t  out_res;
  logic               in_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_id   <= '0;
      source_id <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        dbsf_pkg::REG_DEST_ID:   dest_id   <= cfg_wdata;
        dbsf_pkg::REG_SOURCE_ID: source_id <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign full = cmd_full;

  dbsf_front #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .item       (item),
    .cmd_full   (cmd_full),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in),
    .in_frame   (in_frame)
  );

  dbsf_fifo #(
    .W($bits(dbsf_pkg::cmd_t))
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_head),
    .empty (cmd_empty)
  );

  dbsf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .dest_id   (dest_id),
    .source_id (source_id),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_res   (out_res)
  );

  dbsf_fifo #(
    .W($bits(dbsf_pkg::result_t))
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_res),
    .full  (out_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

  // a frame close always ends the run of its item
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_push && out_res.frame_done |-> out_res.run_last && out_res.out_byte == dbsf_pkg::SYM_ETX)
    else $error("frame close not on last etx byte");

  // the back end only retires a command it is working on
  a_pop_has_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty && out_push)
    else $error("command popped without a transfer");

  // a close command leaves the front with no frame open
  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    cmd_push && cmd_in.close |=> !in_frame)
    else $error("frame still open after close");

endmodule
